[rtl/core/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiply block
// Store geometry, field widths, opcodes, register indexes and the
// controller-to-datapath command/status records.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Store geometry
  localparam int MAX_DIM    = 8;
  localparam int DIM_CAP    = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int IDX_W      = $clog2(DIM_CAP);
  localparam int RAM_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);

  // Field widths
  localparam int OP_W       = 2;
  localparam int POS_W      = 3;
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = 35;
  localparam int DIM_REG_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_REG_W;

  // Opcodes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd4;

  // Controller commands to the datapath
  typedef struct packed {
    logic             load_left;
    logic             load_right;
    logic             rd_en;
    logic             first_term;
    logic             last_term;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] rd_col;
    logic [IDX_W-1:0] rd_k;
    logic             emit;
    logic [POS_W-1:0] emit_row;
    logic [POS_W-1:0] emit_col;
    logic             emit_last;
  } mm_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } mm_status_t;

  // Largest loop index for a dimension register: 0 counts as 1, cap at DIM_CAP
  function automatic logic [IDX_W-1:0] dim_max_idx(input logic [DIM_REG_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > DIM_CAP) begin
      res = IDX_W'(DIM_CAP - 1);
    end else begin
      res = IDX_W'(v - 1'b1);
    end
    return res;
  endfunction

endpackage

[rtl/core/mm_in_if.sv]
// ----------------------------------------------------------------------------
// mm_in_if: input item channel
// Valid/ready channel carrying one load or compute item.
// ----------------------------------------------------------------------------
interface mm_in_if;
  logic                          valid;
  logic                          ready;
  logic [mm_pkg::OP_W-1:0]       op;
  logic [mm_pkg::POS_W-1:0]      row_index;
  logic [mm_pkg::POS_W-1:0]      col_index;
  logic signed [mm_pkg::ELEM_W-1:0] element_value;

  modport source (output valid, op, row_index, col_index, element_value, input ready);
  modport sink   (input valid, op, row_index, col_index, element_value, output ready);
endinterface

[rtl/core/mm_out_if.sv]
// ----------------------------------------------------------------------------
// mm_out_if: result item channel
// Valid/ready channel carrying one product element.
// ----------------------------------------------------------------------------
interface mm_out_if;
  logic                            valid;
  logic                            ready;
  logic [mm_pkg::POS_W-1:0]        out_row;
  logic [mm_pkg::POS_W-1:0]        out_col;
  logic signed [mm_pkg::ACC_W-1:0] product_value;
  logic                            last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

[rtl/core/mm_ram.sv]
// ----------------------------------------------------------------------------
// mm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/mm_datapath.sv]
// ----------------------------------------------------------------------------
// mm_datapath: element stores, multiply-accumulate pipe and output register
// Stores are written on load commands; the MAC pipe reads one term per cycle,
// multiplies, accumulates, and the sum is moved to the output register on emit.
// ----------------------------------------------------------------------------
module mm_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mm_pkg::mm_cmd_t                    cmd,
  output mm_pkg::mm_status_t                 status,
  input  logic [mm_pkg::POS_W-1:0]           in_row,
  input  logic [mm_pkg::POS_W-1:0]           in_col,
  input  logic signed [mm_pkg::ELEM_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mm_pkg::POS_W-1:0]           out_row,
  output logic [mm_pkg::POS_W-1:0]           out_col,
  output logic signed [mm_pkg::ACC_W-1:0]    out_value,
  output logic                               out_last
);

  logic [mm_pkg::ADDR_W-1:0]        wr_addr;
  logic [mm_pkg::ADDR_W-1:0]        left_rd_addr;
  logic [mm_pkg::ADDR_W-1:0]        right_rd_addr;
  logic [mm_pkg::ELEM_W-1:0]        left_rd_data;
  logic [mm_pkg::ELEM_W-1:0]        right_rd_data;
  logic signed [mm_pkg::ELEM_W-1:0] left_term;
  logic signed [mm_pkg::ELEM_W-1:0] right_term;
  logic signed [mm_pkg::PROD_W-1:0] prod_nxt;

  // Read stage, product stage and accumulator
  logic                             s1_valid_r;
  logic                             s1_first_r;
  logic                             s1_last_r;
  logic                             p_valid_r;
  logic                             p_first_r;
  logic                             p_last_r;
  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic signed [mm_pkg::ACC_W-1:0]  acc_r;
  logic                             sum_ready_r;

  // Output register
  logic                             out_valid_r;
  logic [mm_pkg::POS_W-1:0]         out_row_r;
  logic [mm_pkg::POS_W-1:0]         out_col_r;
  logic signed [mm_pkg::ACC_W-1:0]  out_value_r;
  logic                             out_last_r;

  // Store addresses: row * MAX_DIM + col
  assign wr_addr = mm_pkg::ADDR_W'(in_row) * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM)
                 + mm_pkg::ADDR_W'(in_col);
  assign left_rd_addr = mm_pkg::ADDR_W'(cmd.rd_row) * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM)
                      + mm_pkg::ADDR_W'(cmd.rd_k);
  assign right_rd_addr = mm_pkg::ADDR_W'(cmd.rd_k) * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM)
                       + mm_pkg::ADDR_W'(cmd.rd_col);

  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(mm_pkg::RAM_DEPTH)) u_left_ram (
    .clk     (clk),
    .wr_en   (cmd.load_left),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (left_rd_addr),
    .rd_data (left_rd_data)
  );

  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(mm_pkg::RAM_DEPTH)) u_right_ram (
    .clk     (clk),
    .wr_en   (cmd.load_right),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (right_rd_addr),
    .rd_data (right_rd_data)
  );

  // Q8.8 times Q8.8 gives Q16.16
  assign left_term  = left_rd_data;
  assign right_term = right_rd_data;
  assign prod_nxt   = left_term * right_term;

  // Term tags follow the RAM read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      p_valid_r  <= 1'b0;
      p_first_r  <= 1'b0;
      p_last_r   <= 1'b0;
    end else begin
      s1_valid_r <= cmd.rd_en;
      s1_first_r <= cmd.first_term;
      s1_last_r  <= cmd.last_term;
      p_valid_r  <= s1_valid_r;
      p_first_r  <= s1_first_r;
      p_last_r   <= s1_last_r;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      prod_r <= prod_nxt;
    end
  end

  // Accumulator; restarts on the first term of each element
  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      if (p_first_r) begin
        acc_r <= mm_pkg::ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + mm_pkg::ACC_W'(prod_r);
      end
    end
  end

  // Sum complete flag, held until the controller emits it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_ready_r <= 1'b0;
    end else if (cmd.emit) begin
      sum_ready_r <= 1'b0;
    end else if (p_valid_r && p_last_r) begin
      sum_ready_r <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.emit_row;
      out_col_r   <= cmd.emit_col;
      out_value_r <= acc_r;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign status.sum_ready = sum_ready_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

[rtl/core/mm_ctrl.sv]
// ----------------------------------------------------------------------------
// mm_ctrl: controller of the matrix multiply block
// Holds the dimension registers, decodes input items and steps the
// row/column/inner loops that drive the datapath.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mm_pkg::OP_W-1:0]           in_op,
  input  logic [mm_pkg::POS_W-1:0]          in_row,
  input  logic [mm_pkg::POS_W-1:0]          in_col,
  output mm_pkg::mm_cmd_t                   cmd,
  input  mm_pkg::mm_status_t                status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [mm_pkg::IDX_W-1:0]       i_r, i_nxt;
  logic [mm_pkg::IDX_W-1:0]       j_r, j_nxt;
  logic [mm_pkg::IDX_W-1:0]       k_r, k_nxt;
  logic [mm_pkg::DIM_REG_W-1:0]   num_rows_r;
  logic [mm_pkg::DIM_REG_W-1:0]   inner_dim_r;
  logic [mm_pkg::DIM_REG_W-1:0]   num_cols_r;
  logic [mm_pkg::IDX_W-1:0]       row_max;
  logic [mm_pkg::IDX_W-1:0]       inner_max;
  logic [mm_pkg::IDX_W-1:0]       col_max;
  logic                           accept;
  logic                           in_range;
  logic                           last_elem;

  assign row_max   = mm_pkg::dim_max_idx(num_rows_r);
  assign inner_max = mm_pkg::dim_max_idx(inner_dim_r);
  assign col_max   = mm_pkg::dim_max_idx(num_cols_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = (int'(in_row) < mm_pkg::MAX_DIM) && (int'(in_col) < mm_pkg::MAX_DIM);
  assign last_elem = (i_r == row_max) && (j_r == col_max);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;

    cmd            = '0;
    cmd.rd_row     = i_r;
    cmd.rd_col     = j_r;
    cmd.rd_k       = k_r;
    cmd.emit_row   = mm_pkg::POS_W'(i_r);
    cmd.emit_col   = mm_pkg::POS_W'(j_r);
    cmd.emit_last  = last_elem;
    cmd.first_term = (k_r == '0);
    cmd.last_term  = (k_r == inner_max);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            mm_pkg::OP_LOAD_LEFT:  cmd.load_left  = in_range;
            mm_pkg::OP_LOAD_RIGHT: cmd.load_right = in_range;
            mm_pkg::OP_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      // one inner term per cycle
      ST_MAC: begin
        cmd.rd_en = 1'b1;
        if (k_r == inner_max) begin
          k_nxt     = '0;
          state_nxt = ST_WAIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // wait for the sum and a free output register
      ST_WAIT: begin
        if (status.sum_ready && status.out_free) begin
          cmd.emit = 1'b1;
          if (last_elem) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            if (j_r == col_max) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, loop counters and dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      num_rows_r  <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      num_cols_r  <= mm_pkg::DIM_RESET;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          mm_pkg::CFG_NUM_ROWS:  num_rows_r  <= cfg_data;
          mm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
          mm_pkg::CFG_NUM_COLS:  num_cols_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/core/matrix_multiply.sv]
// The block accepts a new item every cycle while idle.
// A compute item produces each product element from one store read pair per inner term
// through the single MAC unit, with registered read, multiply and accumulate stages,
// then moves the sum to the output register.
// No item is accepted while a compute runs. Reset (synchronous, rst_n low) returns the
// controller to idle and all dimension registers to 4; the element stores keep contents.
// ----------------------------------------------------------------------------
// matrix_multiply: Q8.8 matrix multiply with exact Q19.16 results
// Loads left and right matrices into two element stores, then emits every
// product element in row-major order on a compute item.
// ----------------------------------------------------------------------------
module matrix_multiply (
  input  logic                          clk,
  input  logic                          rst_n,
  mm_in_if.sink                         in_if,
  mm_out_if.source                      out_if,
  input  logic                          cfg_wr_en,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::CFG_DATA_W-1:0] cfg_data
);

  mm_pkg::mm_cmd_t    cmd;
  mm_pkg::mm_status_t status;

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_op     (in_if.op),
    .in_row    (in_if.row_index),
    .in_col    (in_if.col_index),
    .cmd       (cmd),
    .status    (status)
  );

  mm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_row    (in_if.row_index),
    .in_col    (in_if.col_index),
    .in_value  (in_if.element_value),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_row   (out_if.out_row),
    .out_col   (out_if.out_col),
    .out_value (out_if.product_value),
    .out_last  (out_if.last)
  );

endmodule

[rtl/core/mm_checker.sv]
// ----------------------------------------------------------------------------
// mm_port_checker: port-level checks of the matrix multiply block
// Watches the item channels and flags ordering or stall errors.
// ----------------------------------------------------------------------------
module mm_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [mm_pkg::OP_W-1:0]       in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mm_pkg::POS_W-1:0]      out_row,
  input logic [mm_pkg::POS_W-1:0]      out_col,
  input logic [mm_pkg::ACC_W-1:0]      out_value,
  input logic                          out_last
);

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
                                && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // A compute item closes the input until its run ends
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == mm_pkg::OP_COMPUTE) |=> !in_ready)
    else $error("input accepted right after a compute item");

  // Mid-run results never coexist with an open input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open while a run is in progress");

  // Nothing follows the last element of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after last element");

endmodule

bind matrix_multiply mm_port_checker u_mm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_row   (out_if.out_row),
  .out_col   (out_if.out_col),
  .out_value (out_if.product_value),
  .out_last  (out_if.last)
);

[tb/mm_checker.sv]
// ----------------------------------------------------------------------------
// mm_checker: scoreboard for the matrix multiply block
// Watches the item channels and the register port. Keeps a shadow of both
// element stores and of the dimension registers, works out every product
// element when a compute item is accepted, and compares each result item
// field by field with the oldest element still owed.
// ----------------------------------------------------------------------------
module mm_checker import mm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mm_in_if                      in_mon,
  mm_out_if                     out_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_products
);

  typedef struct {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } product_t;

  // Shadow stores and dimension registers
  logic signed [ELEM_W-1:0] left_elems  [RAM_DEPTH];
  logic signed [ELEM_W-1:0] right_elems [RAM_DEPTH];
  logic [DIM_REG_W-1:0]     num_rows;
  logic [DIM_REG_W-1:0]     inner_dim;
  logic [DIM_REG_W-1:0]     num_cols;

  product_t expected_products[$];

  // Register value to loop extent: zero acts as one, capped at DIM_CAP
  function automatic int dim_span(input logic [DIM_REG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > DIM_CAP) n = DIM_CAP;
    return n;
  endfunction

  task automatic report(input string msg);
    if (fail_count < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Every product element in row-major order, exact Q19.16 sums
  task automatic queue_products();
    int       rows;
    int       inner;
    int       cols;
    longint   acc;
    product_t p;
    rows  = dim_span(num_rows);
    inner = dim_span(inner_dim);
    cols  = dim_span(num_cols);
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        acc = 0;
        for (int k = 0; k < inner; k++) begin
          acc += longint'(left_elems[i*MAX_DIM + k]) * longint'(right_elems[k*MAX_DIM + j]);
        end
        p.row   = POS_W'(i);
        p.col   = POS_W'(j);
        p.value = ACC_W'(acc);
        p.last  = (i == rows - 1) && (j == cols - 1);
        expected_products.push_back(p);
      end
    end
  endtask

  task automatic check_product();
    product_t want;
    if (expected_products.size() == 0) begin
      report($sformatf("unexpected product element row %0d col %0d value %0d",
                       out_mon.out_row, out_mon.out_col, out_mon.product_value));
    end else begin
      want = expected_products.pop_front();
      if (out_mon.out_row !== want.row)
        report($sformatf("out_row %0d, expected %0d", out_mon.out_row, want.row));
      if (out_mon.out_col !== want.col)
        report($sformatf("out_col %0d, expected %0d", out_mon.out_col, want.col));
      if (out_mon.product_value !== want.value)
        report($sformatf("product_value %0d, expected %0d at row %0d col %0d",
                         out_mon.product_value, want.value, want.row, want.col));
      if (out_mon.last !== want.last)
        report($sformatf("last %0b, expected %0b at row %0d col %0d",
                         out_mon.last, want.last, want.row, want.col));
    end
  endtask

  // Sample both channels and the register port on each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      num_rows   = DIM_RESET;
      inner_dim  = DIM_RESET;
      num_cols   = DIM_RESET;
      fail_count = 0;
      expected_products.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_NUM_ROWS:  num_rows  = cfg_data;
          CFG_INNER_DIM: inner_dim = cfg_data;
          CFG_NUM_COLS:  num_cols  = cfg_data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_product();
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_LOAD_LEFT:  left_elems[in_mon.row_index*MAX_DIM + in_mon.col_index] =
                           in_mon.element_value;
          OP_LOAD_RIGHT: right_elems[in_mon.row_index*MAX_DIM + in_mon.col_index] =
                           in_mon.element_value;
          OP_COMPUTE:    queue_products();
          default: ;  // unused opcode: no effect
        endcase
      end
    end
    pending_products = expected_products.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the matrix multiply block
// Drives load, compute and stray items with random gaps, throttles the
// result channel, changes the dimensions between phases while idle, and
// leaves all checking to mm_checker.
// ----------------------------------------------------------------------------
module testbench;
  import mm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam int              RAND_ITEMS = 210;
  localparam int              LONG_HOLD  = 300;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ELEM_W-1:0] value;
  } elem_load_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_products;

  mm_in_if  in_ch ();
  mm_out_if out_ch ();

  // Stimulus-side bookkeeping
  bit left_written  [RAM_DEPTH];
  bit right_written [RAM_DEPTH];
  bit idle_on;
  bit hold_results;
  int prod_rows;
  int sum_len;
  int prod_cols;
  int items_sent;

  matrix_multiply i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mm_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_products (pending_products)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #50000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int dim_extent(input logic [DIM_REG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > DIM_CAP) return DIM_CAP;
    return int'(v);
  endfunction

  // Mostly small sizes, now and then zero, the cap or beyond it
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_REG_W'(DIM_CAP);
      2:       return DIM_REG_W'($urandom_range(9, 15));
      3:       return DIM_REG_W'($urandom_range(4, 7));
      default: return DIM_REG_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // One item on the input channel; valid stays high into the next item unless a gap is drawn
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic [ELEM_W-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.row_index     <= row;
    in_ch.col_index     <= col;
    in_ch.element_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD_LEFT)  left_written[row*MAX_DIM + col]  = 1'b1;
    if (op == OP_LOAD_RIGHT) right_written[row*MAX_DIM + col] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every owed product element has come, then let the block settle
  task automatic drain();
    @(negedge clk);
    while (pending_products != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dims(input logic [DIM_REG_W-1:0] r, input logic [DIM_REG_W-1:0] k,
                            input logic [DIM_REG_W-1:0] c);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_NUM_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_INNER_DIM;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= CFG_NUM_COLS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prod_rows = dim_extent(r);
    sum_len   = dim_extent(k);
    prod_cols = dim_extent(c);
  endtask

  // Operand loads for the current sizes in random order, plus stray items
  task automatic load_operands();
    elem_load_t plan[$];
    elem_load_t tmp;
    int         j;
    for (int r = 0; r < prod_rows; r++) begin
      for (int k = 0; k < sum_len; k++) begin
        if (!left_written[r*MAX_DIM + k] || $urandom_range(0, 3) == 0)
          plan.push_back('{OP_LOAD_LEFT, POS_W'(r), POS_W'(k), pick_value()});
      end
    end
    for (int k = 0; k < sum_len; k++) begin
      for (int c = 0; c < prod_cols; c++) begin
        if (!right_written[k*MAX_DIM + c] || $urandom_range(0, 3) == 0)
          plan.push_back('{OP_LOAD_RIGHT, POS_W'(k), POS_W'(c), pick_value()});
      end
    end
    repeat ($urandom_range(0, 2)) begin
      tmp.op    = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
      tmp.row   = POS_W'($urandom);
      tmp.col   = POS_W'($urandom);
      tmp.value = pick_value();
      plan.push_back(tmp);
    end
    if ($urandom_range(0, 3) == 0)
      plan.push_back('{OP_UNUSED, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom)});
    for (int i = plan.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end
    foreach (plan[i]) send_item(plan[i].op, plan[i].row, plan[i].col, plan[i].value);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (hold_results) begin
        stall        = LONG_HOLD;
        hold_results = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Main sequence
  initial begin
    int phase;
    int rounds;
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= '0;
    in_ch.row_index     <= '0;
    in_ch.col_index     <= '0;
    in_ch.element_value <= '0;
    idle_on      = 1'b1;
    hold_results = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1x1 with sign extremes, stray opcode, index extremes
    write_dims(4'd0, 4'd1, 4'd1);
    send_item(OP_LOAD_LEFT, 3'd0, 3'd0, 16'h8000);
    send_item(OP_LOAD_RIGHT, 3'd0, 3'd0, 16'h8000);
    send_item(OP_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
    send_item(OP_UNUSED, 3'd5, 3'd2, 16'h1234);
    send_item(OP_LOAD_LEFT, 3'd0, 3'd0, 16'h7FFF);
    send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
    send_item(OP_LOAD_RIGHT, 3'd0, 3'd0, 16'h7FFF);
    send_item(OP_COMPUTE, 3'd3, 3'd4, 16'h5555);
    send_item(OP_LOAD_LEFT, 3'd7, 3'd7, 16'hFFFF);
    send_item(OP_LOAD_RIGHT, 3'd7, 3'd7, 16'h0000);
    release_input();
    drain();

    // Directed: longest inner sum of most negative terms, largest result
    write_dims(4'd1, 4'd15, 4'd0);
    for (int k = 0; k < DIM_CAP; k++) begin
      send_item(OP_LOAD_LEFT, 3'd0, POS_W'(k), 16'h8000);
      send_item(OP_LOAD_RIGHT, POS_W'(k), 3'd0, 16'h8000);
    end
    send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
    release_input();
    drain();

    // Random phases
    items_sent = 0;
    phase      = 0;
    while (items_sent < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        release_input();
        drain();
        write_dims(pick_dim(), pick_dim(), pick_dim());
      end
      if (phase == 2) hold_results = 1'b1;
      rounds = $urandom_range(1, 2);
      repeat (rounds) begin
        load_operands();
        send_item(OP_COMPUTE, POS_W'($urandom), POS_W'($urandom), ELEM_W'($urandom));
      end
      phase++;
    end
    release_input();
    drain();
    repeat (12) @(posedge clk);

    if (fail_count == 0 && pending_products == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mm_pkg.sv
rtl/core/mm_in_if.sv
rtl/core/mm_out_if.sv
rtl/core/mm_ram.sv
rtl/core/mm_datapath.sv
rtl/core/mm_ctrl.sv
rtl/core/matrix_multiply.sv
rtl/core/mm_checker.sv
tb/mm_checker.sv
tb/testbench.sv
